// ----- rtl/mdc_pkg.sv -----
// Shared constants, types and helpers of the multichannel delta codec.
package mdc_pkg;

	localparam int CHANNELS   = 8;
	localparam int WINDOW     = 256;
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int POS_LIMIT  = WINDOW * CHANNELS;
	localparam int POS_W      = $clog2(POS_LIMIT);
	localparam int BYTE_W     = 13;

	localparam logic [BYTE_W-1:0] BYTE_MAX     = {BYTE_W{1'b1}};
	localparam logic [BYTE_W-1:0] HEADER_BYTES = BYTE_W'(4);
	localparam logic [31:0]       POS_MULT     = 32'd131;
	localparam int                RES_MIN      = -127;
	localparam int                RES_MAX      = 127;

	// codec_mode codes; the unused code falls back to raw
	localparam logic [1:0] MODE_RAW    = 2'd0;
	localparam logic [1:0] MODE_ENCODE = 2'd1;
	localparam logic [1:0] MODE_DECODE = 2'd2;

	localparam logic [1:0] COST_NONE  = 2'd0;
	localparam logic [1:0] COST_SHORT = 2'd1;
	localparam logic [1:0] COST_LONG  = 2'd2;

	typedef logic [CH_W-1:0] chan_t;

	typedef struct packed {
		logic signed [31:0] sample_value;
		logic [2:0]         channel_index;
		logic               first_in_channel;
		logic               last_in_chunk;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic [1:0]         residual_cost;
		logic [BYTE_W-1:0]  byte_estimate;
		logic signed [31:0] chunk_checksum;
		logic signed [31:0] total_checksum;
		logic               chunk_done;
	} result_t;

	// chunk-level accumulators
	typedef struct packed {
		logic [BYTE_W-1:0] byte_cnt;
		logic [POS_W-1:0]  pos;
		logic [31:0]       run_sum;
		logic [31:0]       total_sum;
	} acc_t;

	// write request into the previous-value store
	typedef struct packed {
		logic        en;
		chan_t       addr;
		logic [31:0] data;
	} prev_wr_t;

	// channel index mod CHANNELS by repeated compare-subtract (3-bit input)
	function automatic chan_t chan_fold(input logic [2:0] c);
		logic [6:0] v;
		v = {4'b0000, c};
		for (int k = 0; k < 8; k++) begin
			if (v >= 7'(CHANNELS)) begin
				v = v - 7'(CHANNELS);
			end
		end
		return chan_t'(v);
	endfunction

endpackage

// ----- rtl/mdc_ifs.sv -----
// Channel interfaces of the codec: sample input, result output, mode write.
interface mdc_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample_value;
	logic [2:0]         channel_index;
	logic               first_in_channel;
	logic               last_in_chunk;

	modport source (output valid, sample_value, channel_index, first_in_channel,
		last_in_chunk, input ready);
	modport sink (input valid, sample_value, channel_index, first_in_channel,
		last_in_chunk, output ready);
endinterface

interface mdc_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_value;
	logic [1:0]         residual_cost;
	logic [12:0]        byte_estimate;
	logic signed [31:0] chunk_checksum;
	logic signed [31:0] total_checksum;
	logic               chunk_done;

	modport source (output valid, out_value, residual_cost, byte_estimate,
		chunk_checksum, total_checksum, chunk_done, input ready);
	modport sink (input valid, out_value, residual_cost, byte_estimate,
		chunk_checksum, total_checksum, chunk_done, output ready);
	modport monitor (input valid, ready, out_value, residual_cost, byte_estimate,
		chunk_checksum, total_checksum, chunk_done);
endinterface

interface mdc_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] codec_mode;

	modport source (output valid, codec_mode, input ready);
	modport sink (input valid, codec_mode, output ready);
endinterface

// ----- rtl/mdc_prev_ram.sv -----
// Previous-value store: one word per channel, registered read, write-first bypass.
module mdc_prev_ram (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  mdc_pkg::chan_t    rd_addr,
	input  mdc_pkg::prev_wr_t wr,
	output logic [31:0]       rd_data_q
);
	import mdc_pkg::*;

	logic [31:0]         mem [CHANNELS];
	logic [CHANNELS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.en && (wr.addr == rd_addr)) begin
				rd_data_q <= wr.data;
			end else if (valid_q[rd_addr]) begin
				rd_data_q <= mem[rd_addr];
			end else begin
				rd_data_q <= '0;
			end
		end
	end

endmodule

// ----- rtl/mdc_step.sv -----
// Per-sample update: residual/reconstruction, cost, byte count, checksums.
module mdc_step (
	input  logic [1:0]         mode,
	input  mdc_pkg::sample_t   item,
	input  logic [31:0]        prev_data,
	input  mdc_pkg::acc_t      cur,
	output mdc_pkg::result_t   res,
	output mdc_pkg::acc_t      nxt,
	output mdc_pkg::prev_wr_t  wr
);
	import mdc_pkg::*;

	logic [31:0]       smp;
	logic [31:0]       x16;
	logic [31:0]       p16;
	logic [31:0]       enc_res;
	logic [1:0]        cost;
	logic [BYTE_W:0]   sum1;
	logic [BYTE_W-1:0] sat1;
	logic [BYTE_W:0]   sum2;
	logic [BYTE_W-1:0] est;
	logic [31:0]       dec_x;
	logic [31:0]       chk_x;
	logic [31:0]       pos_term;
	logic [31:0]       run_new;
	logic [POS_W-1:0]  pos_inc;

	always_comb begin
		smp      = item.sample_value;
		x16      = {{16{smp[15]}}, smp[15:0]};
		p16      = {{16{prev_data[15]}}, prev_data[15:0]};
		enc_res  = item.first_in_channel ? x16 : (x16 - p16);
		cost     = (($signed(enc_res) >= RES_MIN) && ($signed(enc_res) <= RES_MAX))
			? COST_SHORT : COST_LONG;

		// saturating byte count, header added on the chunk's last sample
		sum1 = {1'b0, cur.byte_cnt} + (BYTE_W + 1)'(cost);
		sat1 = (sum1 > {1'b0, BYTE_MAX}) ? BYTE_MAX : sum1[BYTE_W-1:0];
		sum2 = {1'b0, sat1} + {1'b0, HEADER_BYTES};
		if (item.last_in_chunk) begin
			est = (sum2 > {1'b0, BYTE_MAX}) ? BYTE_MAX : sum2[BYTE_W-1:0];
		end else begin
			est = sat1;
		end

		dec_x    = item.first_in_channel ? smp : (prev_data + smp);
		chk_x    = (mode == MODE_DECODE) ? dec_x : smp;
		pos_term = 32'(cur.pos) * POS_MULT;
		run_new  = cur.run_sum ^ (chk_x + pos_term);
		pos_inc  = (cur.pos == POS_W'(POS_LIMIT - 1)) ? '0 : (cur.pos + 1'b1);
	end

	always_comb begin
		res.chunk_done = item.last_in_chunk;
		nxt.pos        = item.last_in_chunk ? '0 : pos_inc;
		wr.addr        = chan_fold(item.channel_index);
		case (mode)
			MODE_ENCODE: begin
				res.out_value      = enc_res;
				res.residual_cost  = cost;
				res.byte_estimate  = est;
				res.chunk_checksum = cur.run_sum;
				res.total_checksum = cur.total_sum;
				nxt.byte_cnt       = item.last_in_chunk ? '0 : est;
				nxt.run_sum        = item.last_in_chunk ? '0 : cur.run_sum;
				nxt.total_sum      = cur.total_sum;
				wr.en              = 1'b1;
				wr.data            = x16;
			end
			default: begin
				// raw and decode share the checksum path
				res.out_value      = chk_x;
				res.residual_cost  = COST_NONE;
				res.byte_estimate  = '0;
				res.chunk_checksum = run_new;
				res.total_checksum = item.last_in_chunk ? (cur.total_sum ^ run_new)
					: cur.total_sum;
				nxt.byte_cnt       = item.last_in_chunk ? '0 : cur.byte_cnt;
				nxt.run_sum        = item.last_in_chunk ? '0 : run_new;
				nxt.total_sum      = res.total_checksum;
				wr.en              = (mode == MODE_DECODE);
				wr.data            = dec_x;
			end
		endcase
	end

endmodule

// ----- rtl/multichannel_delta_codec_core.sv -----
// Top level of the multichannel delta codec.
//
// Channels: "samples" takes one sample per request (value, channel, first-in-
// channel and last-in-chunk flags); "results" returns exactly one result per
// sample, in order; "cfg" writes codec_mode (0 raw, 1 encode, 2 decode, 3 as
// raw) and is always ready. Write the mode only while no sample is in flight.
// Path: an accepted sample is registered into the compute stage, and its result
// is registered into the output register when the compute stage retires it.
// Throughput: one sample per cycle while results.ready stays high. The previous
// value of each channel sits in a small synchronous RAM read at acceptance; the
// read-modify-write closes when the sample retires from the compute stage, and
// a write-first bypass in the RAM covers back-to-back samples of the same channel.
// Reset: mode returns to encode, byte count, position and both checksums clear,
// and every channel's previous value reads as zero until written.
// Stall: while the receiver holds results.ready low the output register keeps
// its request, one more sample waits in the compute stage, and samples.ready
// drops after that.
module multichannel_delta_codec_core (
	input logic         clk,
	input logic         arst_n,
	mdc_sample_if.sink  samples,
	mdc_result_if.source results,
	mdc_cfg_if.sink     cfg
);
	import mdc_pkg::*;

	logic [1:0] mode_q;

	// compute stage
	logic        s1_valid;
	sample_t     item_s1;
	logic [31:0] prev_rd;
	acc_t        acc_q;

	// output register
	logic    out_valid_q;
	result_t res_q;

	result_t  step_res;
	acc_t     step_acc;
	prev_wr_t step_wr;
	prev_wr_t ram_wr;

	logic    out_free;
	logic    s1_fire;
	logic    accept;
	sample_t in_item;

	assign out_free = !out_valid_q || results.ready;
	assign s1_fire  = s1_valid && out_free;
	assign samples.ready = !s1_valid || s1_fire;
	assign accept   = samples.valid && samples.ready;
	assign cfg.ready = 1'b1;

	assign in_item.sample_value     = samples.sample_value;
	assign in_item.channel_index    = samples.channel_index;
	assign in_item.first_in_channel = samples.first_in_channel;
	assign in_item.last_in_chunk    = samples.last_in_chunk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENCODE;
		end else if (cfg.valid) begin
			mode_q <= cfg.codec_mode;
		end
	end

	// previous-value RAM: read issued with the request, written when it retires
	assign ram_wr.en   = s1_fire && step_wr.en;
	assign ram_wr.addr = step_wr.addr;
	assign ram_wr.data = step_wr.data;

	mdc_prev_ram u_prev_ram (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr   (chan_fold(samples.channel_index)),
		.wr        (ram_wr),
		.rd_data_q (prev_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (s1_fire) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	mdc_step u_step (
		.mode      (mode_q),
		.item      (item_s1),
		.prev_data (prev_rd),
		.cur       (acc_q),
		.res       (step_res),
		.nxt       (step_acc),
		.wr        (step_wr)
	);

	// chunk accumulators advance once per retired sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (s1_fire) begin
			acc_q <= step_acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_q <= step_res;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.out_value      = res_q.out_value;
	assign results.residual_cost  = res_q.residual_cost;
	assign results.byte_estimate  = res_q.byte_estimate;
	assign results.chunk_checksum = res_q.chunk_checksum;
	assign results.total_checksum = res_q.total_checksum;
	assign results.chunk_done     = res_q.chunk_done;

endmodule

// ----- rtl/mdc_checker.sv -----
// Port-level checks on the codec's result channel, bound to the top level.
module mdc_checker (
	input logic           clk,
	input logic           arst_n,
	mdc_result_if.source  results
);
	import mdc_pkg::*;

	logic [31:0] prev_total_q;
	logic        seen_q;

	// total checksum of the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (results.valid && results.ready) begin
			seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (results.valid && results.ready) begin
			prev_total_q <= results.total_checksum;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.ready |=> results.valid
			&& $stable(results.out_value) && $stable(results.total_checksum))
		else $error("result changed while stalled");

	a_no_cost_no_estimate: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.residual_cost == COST_NONE)
			|-> (results.byte_estimate == '0))
		else $error("byte estimate outside encode mode");

	a_chunk_end_header: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.chunk_done && (results.residual_cost != COST_NONE)
			|-> (results.byte_estimate >= 13'd5))
		else $error("chunk end estimate misses header bytes");

	a_total_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && seen_q && !results.chunk_done
			|-> (results.total_checksum == prev_total_q))
		else $error("total checksum moved without chunk end");

endmodule

bind multichannel_delta_codec_core mdc_checker u_mdc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.results (results)
);
